// File: rtl/core/dtrh_pkg.sv
// ----------------------------------------------------------------------------
// dtrh_pkg
// Shared types, constants and tables for the dew point to humidity pipeline.
// ----------------------------------------------------------------------------
package dtrh_pkg;

  // quotient, remainder and divisor widths of the term divider
  localparam int unsigned QW = 38;
  localparam int unsigned RW = 28;
  localparam int unsigned DW = 27;
  // signed term and exponent width
  localparam int unsigned TW = 40;
  // q30 fraction, q30 value and running sum widths
  localparam int unsigned FW = 30;
  localparam int unsigned VW = 31;
  localparam int unsigned SW = 33;
  localparam int unsigned KW = 4;

  localparam int unsigned NTERMS = 14;
  localparam int unsigned KMAX = 9;
  localparam int unsigned DIV_STEP_DEF = 2;

  localparam logic [14:0] B1000_WARM = 15'd17368;
  localparam logic [14:0] C100_WARM  = 15'd23888;
  localparam logic [14:0] B1000_COLD = 15'd17966;
  localparam logic [14:0] C100_COLD  = 15'd24715;

  localparam logic [VW-1:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [28:0]   EXP_M1_Q30 = 29'd395007543;
  localparam logic [29:0]   HALF_Q30   = 30'h2000_0000;
  localparam logic [13:0]   CENTI_MAX  = 14'd10000;
  localparam logic [7:0]    K_ZERO     = 8'd10;

  typedef struct packed {
    logic signed [15:0] temperature_q8;
    logic signed [15:0] dew_point_q8;
  } dtrh_in_t;

  typedef struct packed {
    logic [13:0] humidity_centi;
    logic        was_clamped;
  } dtrh_out_t;

  typedef struct packed {
    logic          sat;
    logic          zero;
    logic [KW-1:0] k;
    logic [FW-1:0] f;
  } dtrh_exp_t;

  typedef struct packed {
    logic          sat;
    logic          zero;
    logic [KW-1:0] k;
    logic [VW-1:0] v;
  } dtrh_pow_t;

  // ceil(2^32 / n) for the taylor divisions
  function automatic logic [32:0] dtrh_recip(input int unsigned n);
    logic [32:0] r;
    case (n)
      1:       r = 33'd4294967296;
      2:       r = 33'd2147483648;
      3:       r = 33'd1431655766;
      4:       r = 33'd1073741824;
      5:       r = 33'd858993460;
      6:       r = 33'd715827883;
      7:       r = 33'd613566757;
      8:       r = 33'd536870912;
      9:       r = 33'd477218589;
      10:      r = 33'd429496730;
      11:      r = 33'd390451573;
      12:      r = 33'd357913942;
      13:      r = 33'd330382100;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/dtrh_term_div.sv
// ----------------------------------------------------------------------------
// dtrh_term_div
// Forms both Magnus terms b*x/(c+x) in Q32 with a pipelined restoring
// divider, rounds them and splits the exponent into integer and fraction.
// ----------------------------------------------------------------------------
module dtrh_term_div #(
  parameter int unsigned DIV_STEP = dtrh_pkg::DIV_STEP_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dtrh_pkg::dtrh_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dtrh_pkg::dtrh_exp_t out_data_o
);

  localparam int unsigned QW   = dtrh_pkg::QW;
  localparam int unsigned RW   = dtrh_pkg::RW;
  localparam int unsigned DW   = dtrh_pkg::DW;
  localparam int unsigned TW   = dtrh_pkg::TW;
  localparam int unsigned NDIV = (QW + DIV_STEP - 1) / DIV_STEP;
  localparam int unsigned NST  = NDIV + 3;

  typedef struct packed {
    logic          neg;
    logic [DW-1:0] den;
    logic [RW-1:0] rem;
    logic [QW-1:0] qs;
  } div_op_t;

  typedef struct packed {
    div_op_t dp;
    div_op_t tp;
  } div_pair_t;

  function automatic div_op_t prep_op(input logic signed [15:0] x, input logic [14:0] b,
                                      input logic [14:0] c);
    logic [15:0]        mag;
    logic [29:0]        bm;
    logic signed [25:0] d;
    div_op_t            op;
    mag    = x[15] ? 16'(-x) : 16'(x);
    bm     = 30'({14'b0, mag} * {15'b0, b});
    d      = $signed({3'b000, c, 8'h00}) + 26'(x) * 26'sd100;
    op.neg = x[15];
    op.den = 27'(d[23:0]) * 27'd10;
    op.rem = RW'(bm[29:6]);
    op.qs  = {bm[5:0], 32'h0};
    return op;
  endfunction

  function automatic div_op_t div_bit(input div_op_t op);
    logic [RW-1:0] sh;
    div_op_t       r;
    r    = op;
    sh   = {op.rem[RW-2:0], op.qs[QW-1]};
    r.qs = {op.qs[QW-2:0], 1'b0};
    if (sh >= {1'b0, op.den}) begin
      r.rem   = sh - {1'b0, op.den};
      r.qs[0] = 1'b1;
    end else begin
      r.rem = sh;
    end
    return r;
  endfunction

  function automatic logic signed [TW-1:0] round_term(input div_op_t op);
    logic [DW-1:0]        half;
    logic [QW:0]          q;
    logic signed [TW-1:0] m;
    half = op.den >> 1;
    q    = {1'b0, op.qs} + {{QW{1'b0}}, (op.rem >= {1'b0, op.den - half})};
    m    = signed'(TW'(q));
    return op.neg ? -m : m;
  endfunction

  logic [NST-1:0]       valid_q;
  logic [NST-1:0]       load;
  logic [NST-1:0]       valid_src;
  div_pair_t            pair_q [NDIV+1];
  div_pair_t            pair_d [NDIV+1];
  div_pair_t            prep_d;
  logic signed [TW-1:0] term_dp_q, term_t_q;
  logic signed [TW-1:0] e_d, y_d;
  dtrh_pkg::dtrh_exp_t  exp_q, exp_d;
  logic                 warm;

  // stall chain
  always_comb begin
    load[NST-1] = ~valid_q[NST-1] | out_ready_i;
    for (int s = NST - 2; s >= 0; s--) begin
      load[s] = ~valid_q[s] | load[s+1];
    end
  end

  assign in_ready_o  = load[0];
  assign valid_src   = {valid_q[NST-2:0], in_valid_i};
  assign out_valid_o = valid_q[NST-1];
  assign out_data_o  = exp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < NST; s++) begin
        if (load[s]) begin
          valid_q[s] <= valid_src[s];
        end
      end
    end
  end

  always_comb begin
    warm = !in_data_i.temperature_q8[15] && (in_data_i.temperature_q8 != 16'sd0);
    if (warm) begin
      prep_d.dp = prep_op(in_data_i.dew_point_q8, dtrh_pkg::B1000_WARM, dtrh_pkg::C100_WARM);
      prep_d.tp = prep_op(in_data_i.temperature_q8, dtrh_pkg::B1000_WARM,
                          dtrh_pkg::C100_WARM);
    end else begin
      prep_d.dp = prep_op(in_data_i.dew_point_q8, dtrh_pkg::B1000_COLD, dtrh_pkg::C100_COLD);
      prep_d.tp = prep_op(in_data_i.temperature_q8, dtrh_pkg::B1000_COLD,
                          dtrh_pkg::C100_COLD);
    end
  end

  // divider stages, up to DIV_STEP quotient bits each
  always_comb begin
    pair_d[0] = prep_d;
    for (int s = 1; s <= NDIV; s++) begin
      pair_d[s] = pair_q[s-1];
      for (int j = 0; j < DIV_STEP; j++) begin
        if ((s - 1) * DIV_STEP + j < QW) begin
          pair_d[s].dp = div_bit(pair_d[s].dp);
          pair_d[s].tp = div_bit(pair_d[s].tp);
        end
      end
    end
  end

  always_comb begin
    e_d        = term_dp_q - term_t_q;
    y_d        = -e_d;
    exp_d.sat  = !e_d[TW-1] && (e_d != '0);
    exp_d.zero = (y_d[TW-1:32] >= dtrh_pkg::K_ZERO);
    exp_d.k    = y_d[35:32];
    exp_d.f    = y_d[31:2];
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s <= NDIV; s++) begin
      if (load[s]) begin
        pair_q[s] <= pair_d[s];
      end
    end
    if (load[NDIV+1]) begin
      term_dp_q <= round_term(pair_q[NDIV].dp);
      term_t_q  <= round_term(pair_q[NDIV].tp);
    end
    if (load[NDIV+2]) begin
      exp_q <= exp_d;
    end
  end

endmodule

// File: rtl/core/dtrh_exp_taylor.sv
// ----------------------------------------------------------------------------
// dtrh_exp_taylor
// exp(-f) in Q30 as a truncated Taylor sum, three register stages per term:
// multiply, reciprocal divide, correct and accumulate.
// ----------------------------------------------------------------------------
module dtrh_exp_taylor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dtrh_pkg::dtrh_exp_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dtrh_pkg::dtrh_pow_t out_data_o
);

  localparam int unsigned FW  = dtrh_pkg::FW;
  localparam int unsigned VW  = dtrh_pkg::VW;
  localparam int unsigned SW  = dtrh_pkg::SW;
  localparam int unsigned KW  = dtrh_pkg::KW;
  localparam int unsigned NT  = dtrh_pkg::NTERMS - 1;
  localparam int unsigned NTS = 3 * NT;
  localparam int unsigned NS  = NTS + 1;
  localparam int unsigned PW  = VW + FW;
  localparam int unsigned MW  = FW + 33;
  localparam int unsigned CW  = VW + 4;

  typedef struct packed {
    logic                 sat;
    logic                 zero;
    logic [KW-1:0]        k;
    logic [FW-1:0]        f;
    logic signed [SW-1:0] sum;
    logic [VW-1:0]        term;
    logic [FW-1:0]        x;
    logic [VW-1:0]        qe;
  } tay_t;

  logic [NS-1:0]       valid_q;
  logic [NS-1:0]       load;
  logic [NS-1:0]       valid_src;
  tay_t                st_q   [NTS];
  tay_t                st_d   [NTS];
  tay_t                src    [NTS];
  dtrh_pkg::dtrh_pow_t pw_q, pw_d;

  always_comb begin
    load[NS-1] = ~valid_q[NS-1] | out_ready_i;
    for (int s = NS - 2; s >= 0; s--) begin
      load[s] = ~valid_q[s] | load[s+1];
    end
  end

  assign in_ready_o  = load[0];
  assign valid_src   = {valid_q[NS-2:0], in_valid_i};
  assign out_valid_o = valid_q[NS-1];
  assign out_data_o  = pw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (load[s]) begin
          valid_q[s] <= valid_src[s];
        end
      end
    end
  end

  always_comb begin
    src[0].sat  = in_data_i.sat;
    src[0].zero = in_data_i.zero;
    src[0].k    = in_data_i.k;
    src[0].f    = in_data_i.f;
    src[0].sum  = signed'(SW'(dtrh_pkg::ONE_Q30));
    src[0].term = dtrh_pkg::ONE_Q30;
    src[0].x    = '0;
    src[0].qe   = '0;
    for (int s = 1; s < NTS; s++) begin
      src[s] = st_q[s-1];
    end
  end

  always_comb begin
    logic [PW-1:0] p;
    logic [MW-1:0] m;
    logic [CW-1:0] qn;
    logic [VW-1:0] t;
    int            s;
    for (int n = 1; n <= NT; n++) begin
      // multiply by the fraction
      s        = 3 * (n - 1);
      st_d[s]  = src[s];
      p        = PW'(src[s].term) * PW'(src[s].f);
      st_d[s].x = p[2*FW-1:FW];
      // estimate x / n by reciprocal, at most one too large
      s          = s + 1;
      st_d[s]    = src[s];
      m          = MW'(src[s].x) * MW'(dtrh_pkg::dtrh_recip(n));
      st_d[s].qe = m[MW-1:32];
      // correct and accumulate with alternating sign
      s       = s + 1;
      st_d[s] = src[s];
      qn      = CW'(src[s].qe) * CW'(n);
      t       = (qn > CW'(src[s].x)) ? src[s].qe - 1'b1 : src[s].qe;
      st_d[s].term = t;
      if ((n & 1) == 1) begin
        st_d[s].sum = src[s].sum - signed'(SW'(t));
      end else begin
        st_d[s].sum = src[s].sum + signed'(SW'(t));
      end
    end
  end

  always_comb begin
    pw_d.sat  = st_q[NTS-1].sat;
    pw_d.zero = st_q[NTS-1].zero;
    pw_d.k    = st_q[NTS-1].k;
    if (st_q[NTS-1].sum < 0) begin
      pw_d.v = '0;
    end else if (st_q[NTS-1].sum > signed'(SW'(dtrh_pkg::ONE_Q30))) begin
      pw_d.v = dtrh_pkg::ONE_Q30;
    end else begin
      pw_d.v = st_q[NTS-1].sum[VW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NTS; s++) begin
      if (load[s]) begin
        st_q[s] <= st_d[s];
      end
    end
    if (load[NS-1]) begin
      pw_q <= pw_d;
    end
  end

endmodule

// File: rtl/core/dtrh_pow_scale.sv
// ----------------------------------------------------------------------------
// dtrh_pow_scale
// Applies exp(-1) once per integer unit of the exponent, then scales the
// Q30 ratio to hundredths of a percent with saturation.
// ----------------------------------------------------------------------------
module dtrh_pow_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dtrh_pkg::dtrh_pow_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dtrh_pkg::dtrh_out_t out_data_o
);

  localparam int unsigned VW   = dtrh_pkg::VW;
  localparam int unsigned KW   = dtrh_pkg::KW;
  localparam int unsigned KMAX = dtrh_pkg::KMAX;
  localparam int unsigned NS   = KMAX + 1;
  localparam int unsigned XW   = 60;
  localparam int unsigned CW   = 46;

  logic [NS-1:0]       valid_q;
  logic [NS-1:0]       load;
  logic [NS-1:0]       valid_src;
  dtrh_pkg::dtrh_pow_t pw_q  [KMAX];
  dtrh_pkg::dtrh_pow_t pw_d  [KMAX];
  dtrh_pkg::dtrh_pow_t src   [KMAX];
  dtrh_pkg::dtrh_out_t out_q, out_d;
  logic [CW-1:0]       scaled;
  logic [15:0]         centi;

  always_comb begin
    load[NS-1] = ~valid_q[NS-1] | out_ready_i;
    for (int s = NS - 2; s >= 0; s--) begin
      load[s] = ~valid_q[s] | load[s+1];
    end
  end

  assign in_ready_o  = load[0];
  assign valid_src   = {valid_q[NS-2:0], in_valid_i};
  assign out_valid_o = valid_q[NS-1];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (load[s]) begin
          valid_q[s] <= valid_src[s];
        end
      end
    end
  end

  always_comb begin
    logic [XW-1:0] pr;
    src[0] = in_data_i;
    for (int j = 1; j < KMAX; j++) begin
      src[j] = pw_q[j-1];
    end
    for (int j = 0; j < KMAX; j++) begin
      pw_d[j] = src[j];
      pr      = XW'(src[j].v) * XW'(dtrh_pkg::EXP_M1_Q30) + XW'(dtrh_pkg::HALF_Q30);
      if (src[j].k > KW'(j)) begin
        pw_d[j].v = VW'(pr[XW-1:30]);
      end
    end
  end

  always_comb begin
    scaled = CW'(pw_q[KMAX-1].v) * CW'(dtrh_pkg::CENTI_MAX) + CW'(dtrh_pkg::HALF_Q30);
    centi  = scaled[CW-1:30];
    if (pw_q[KMAX-1].sat) begin
      out_d.humidity_centi = dtrh_pkg::CENTI_MAX;
      out_d.was_clamped    = 1'b1;
    end else if (pw_q[KMAX-1].zero) begin
      out_d.humidity_centi = '0;
      out_d.was_clamped    = 1'b0;
    end else begin
      out_d.humidity_centi = (centi > 16'(dtrh_pkg::CENTI_MAX)) ? dtrh_pkg::CENTI_MAX
                                                                 : centi[13:0];
      out_d.was_clamped    = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < KMAX; j++) begin
      if (load[j]) begin
        pw_q[j] <= pw_d[j];
      end
    end
    if (load[NS-1]) begin
      out_q <= out_d;
    end
  end

endmodule

// File: rtl/core/dewpoint_to_relative_humidity.sv
// ----------------------------------------------------------------------------
// dewpoint_to_relative_humidity
// Relative humidity from air temperature and dew point by the Magnus formula.
// ----------------------------------------------------------------------------
// Fully pipelined: one temperature and dew point transaction is taken every
// cycle unless a stall on the output has filled every stage. The stages include
// the restoring divider stages, three stages per Taylor term of exp(-f) and one
// multiply stage per integer unit of the exponent. Every stage holds its own
// valid bit, so a stall on the output fills empty stages first and input is
// still taken while any stage has room. Results are in hundredths of a
// percent, with was_clamped set when the formula goes above 100 %.
// ----------------------------------------------------------------------------
module dewpoint_to_relative_humidity #(
  parameter int unsigned DIV_STEP = dtrh_pkg::DIV_STEP_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dtrh_pkg::dtrh_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dtrh_pkg::dtrh_out_t out_data_o
);

  logic                exp_valid, exp_ready;
  dtrh_pkg::dtrh_exp_t exp_data;
  logic                pow_valid, pow_ready;
  dtrh_pkg::dtrh_pow_t pow_data;

  dtrh_term_div #(
    .DIV_STEP (DIV_STEP)
  ) u_term_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (exp_valid),
    .out_ready_i (exp_ready),
    .out_data_o  (exp_data)
  );

  dtrh_exp_taylor u_exp_taylor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (exp_valid),
    .in_ready_o  (exp_ready),
    .in_data_i   (exp_data),
    .out_valid_o (pow_valid),
    .out_ready_i (pow_ready),
    .out_data_o  (pow_data)
  );

  dtrh_pow_scale u_pow_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pow_valid),
    .in_ready_o  (pow_ready),
    .in_data_i   (pow_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/core/dtrh_checker.sv
// ----------------------------------------------------------------------------
// dtrh_checker
// Port-level checks of the humidity pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module dtrh_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input dtrh_pkg::dtrh_out_t out_data_o
);

  // output transaction holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.humidity_centi <= dtrh_pkg::CENTI_MAX)
    else $error("humidity above full scale");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.was_clamped |-> out_data_o.humidity_centi == dtrh_pkg::CENTI_MAX)
    else $error("clamped result not at full scale");

  // an empty or draining output stage leaves room at the input
  assert property (@(posedge clk_i)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled with room in the pipeline");

  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind dewpoint_to_relative_humidity dtrh_checker u_dtrh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for dewpoint_to_relative_humidity: directed corner cases, then
// random temperature and dew point pairs under random idling on both sides.
// A scoreboard predicts each humidity result in fixed point and checks the
// results in order.
// ----------------------------------------------------------------------------
module tb;

  localparam longint LIMIT_CYCLES = 2000000;
  localparam int N_RANDOM = 1500;

  class humidity_scoreboard;
    dtrh_pkg::dtrh_out_t pending[$];
    int errors;

    function longint magnus_q32(longint x, longint unsigned b1000, longint c100);
      longint d;
      longint unsigned den, mag, num, q;
      d = c100 * 256 + 100 * x;
      den = longint'(d) * 10;
      mag = (x < 0) ? -x : x;
      num = (b1000 * mag) << 32;
      q = (num + den / 2) / den;
      return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint exp_neg_q30(longint f);
      longint sum, term;
      sum = longint'(1) << 30;
      term = sum;
      for (int n = 1; n < dtrh_pkg::NTERMS; n++) begin
        term = ((term * f) >>> 30) / n;
        if (n & 1) sum -= term;
        else sum += term;
      end
      if (sum < 0) sum = 0;
      if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
      return sum;
    endfunction

    function void note_input(dtrh_pkg::dtrh_in_t x);
      longint t, dp, c100, e, v, e1;
      longint unsigned b1000, y, k, centi;
      dtrh_pkg::dtrh_out_t r;
      t = x.temperature_q8;
      dp = x.dew_point_q8;
      if (t > 0) begin
        b1000 = dtrh_pkg::B1000_WARM;
        c100 = dtrh_pkg::C100_WARM;
      end else begin
        b1000 = dtrh_pkg::B1000_COLD;
        c100 = dtrh_pkg::C100_COLD;
      end
      e = magnus_q32(dp, b1000, c100) - magnus_q32(t, b1000, c100);
      if (e > 0) begin
        r.humidity_centi = dtrh_pkg::CENTI_MAX;
        r.was_clamped = 1'b1;
      end else begin
        y = -e;
        k = y >> 32;
        r.was_clamped = 1'b0;
        if (k >= 10) begin
          r.humidity_centi = '0;
        end else begin
          v = exp_neg_q30(longint'((y & 64'hFFFF_FFFF) >> 2));
          e1 = exp_neg_q30(longint'(1) << 30);
          for (longint unsigned i = 0; i < k; i++) v = (v * e1 + (longint'(1) << 29)) >>> 30;
          centi = (longint'(v) * 10000 + (longint'(1) << 29)) >> 30;
          if (centi > 10000) centi = 10000;
          r.humidity_centi = centi[13:0];
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(dtrh_pkg::dtrh_out_t got);
      dtrh_pkg::dtrh_out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %0d/%0b", got.humidity_centi,
                                   got.was_clamped);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %0d/%0b, got %0d/%0b", want.humidity_centi,
                   want.was_clamped, got.humidity_centi, got.was_clamped);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  dtrh_pkg::dtrh_in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  dtrh_pkg::dtrh_out_t out_data_o;

  humidity_scoreboard sb = new();
  longint cycles;
  bit busy_sender;
  bit busy_receiver;
  int stall_left;

  dewpoint_to_relative_humidity DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_input(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || busy_receiver) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send(input dtrh_pkg::dtrh_in_t x);
    int gap;
    gap = 0;
    if (!busy_sender && $urandom_range(0, 99) < 35)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= x;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_deg(input int t, input int dp);
    dtrh_pkg::dtrh_in_t x;
    x.temperature_q8 = t[15:0];
    x.dew_point_q8 = dp[15:0];
    send(x);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    dtrh_pkg::dtrh_in_t x;
    int t;
    cycles = 0;
    stall_left = 0;
    busy_sender = 0;
    busy_receiver = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_deg(32767, 32767);
    send_deg(-32768, -32768);
    send_deg(32767, -32768);
    send_deg(-32768, 32767);
    send_deg(0, 0);
    send_deg(1, 1);
    send_deg(1, 0);
    send_deg(0, 1);
    send_deg(-1, -1);
    send_deg(-1, 0);
    send_deg(25 * 256, 25 * 256);
    send_deg(25 * 256, 30 * 256);
    send_deg(25 * 256, 15 * 256);
    send_deg(-10 * 256, -12 * 256);
    send_deg(-10 * 256, -5 * 256);
    send_deg(100 * 256, -50 * 256);
    send_deg(127 * 256, -120 * 256);
    send_deg(30 * 256, 29 * 256 + 255);
    send_deg(16'h5555, 16'haaaa);
    send_deg(16'haaaa, 16'h5555);
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 200 == 100) busy_sender = ~busy_sender;
      if (i % 300 == 150) busy_receiver = ~busy_receiver;
      if (i == N_RANDOM / 2) drain();
      case ($urandom_range(0, 9))
        0, 1: begin
          x = $urandom;
          send(x);
        end
        2: begin
          t = $urandom_range(0, 65535) - 32768;
          send_deg(t, t);
        end
        default: begin
          t = $urandom_range(0, 100 * 256) - 40 * 256;
          send_deg(t, t - $urandom_range(0, 45 * 256) + 256);
        end
      endcase
    end
    in_valid_i <= 1'b0;
    busy_receiver = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
